// ----- hdl/owtm_pkg.sv -----
package owtm_pkg;

    localparam int unsigned CfgWidth = 10;
    localparam int unsigned NumCfg   = 8;
    localparam int unsigned CfgIdxW  = 3;

    typedef enum logic [2:0] {
        REQ_NONE  = 3'd0,
        REQ_RESET = 3'd1,
        REQ_WRITE = 3'd2,
        REQ_READ  = 3'd3,
        REQ_TEMP  = 3'd4
    } t_req;

    localparam logic [CfgIdxW-1:0] CFG_RST_LOW   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_RST_REL   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_PRES_WAIT = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PRES_END  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SHORT     = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_LONG      = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_RD_SAMPLE = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_RD_TAIL   = 3'd7;

    localparam logic [CfgWidth-1:0] DEF_RST_LOW   = 10'd750;
    localparam logic [CfgWidth-1:0] DEF_RST_REL   = 10'd60;
    localparam logic [CfgWidth-1:0] DEF_PRES_WAIT = 10'd400;
    localparam logic [CfgWidth-1:0] DEF_PRES_END  = 10'd480;
    localparam logic [CfgWidth-1:0] DEF_SHORT     = 10'd3;
    localparam logic [CfgWidth-1:0] DEF_LONG      = 10'd65;
    localparam logic [CfgWidth-1:0] DEF_RD_SAMPLE = 10'd4;
    localparam logic [CfgWidth-1:0] DEF_RD_TAIL   = 10'd55;

    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

    localparam logic [3:0] STEP_RESET_A = 4'd0;
    localparam logic [3:0] STEP_SKIP_A  = 4'd1;
    localparam logic [3:0] STEP_CONVERT = 4'd2;
    localparam logic [3:0] STEP_RESET_B = 4'd3;
    localparam logic [3:0] STEP_SKIP_B  = 4'd4;
    localparam logic [3:0] STEP_RD_PAD  = 4'd5;
    localparam logic [3:0] STEP_RD_LO   = 4'd6;
    localparam logic [3:0] STEP_RD_HI   = 4'd7;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] wr_byte;
        logic       line_in;
    } t_in_item;

    typedef struct packed {
        logic               line_pull_low;
        logic               busy_res;
        logic               done_res;
        logic               presence_fail;
        logic [7:0]         rd_byte;
        logic signed [15:0] temperature;
    } t_out_item;

endpackage

// ----- hdl/one_wire_temperature_master_top.sv -----
// Each input transfer's result is registered in the output register.
// Throughput: one tick item per cycle; input is stalled only while a result
// waits in the output register and the output side stalls.
// Reset (i_rst_n low, synchronous): bus state machine idle, all counters and
// held results cleared, timing registers back to their defaults.
module one_wire_temperature_master_top #(
    parameter int unsigned COUNTER_WIDTH = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  owtm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output owtm_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [owtm_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [owtm_pkg::CfgWidth-1:0]       i_cfg_data
);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_REL   = 4'd2,
        PH_PRES_WAIT = 4'd3,
        PH_PRES_END  = 4'd4,
        PH_WR_LOW    = 4'd5,
        PH_WR_REC    = 4'd6,
        PH_RD_LOW    = 4'd7,
        PH_RD_WAIT   = 4'd8,
        PH_RD_TAIL   = 4'd9
    } t_phase;

    localparam int unsigned CW = COUNTER_WIDTH;

    logic [owtm_pkg::CfgWidth-1:0] r_cfg [owtm_pkg::NumCfg];

    t_phase              r_phase, n_phase;
    logic [CW-1:0]       r_tick, n_tick;
    logic [2:0]          r_bit_idx, n_bit_idx;
    logic [7:0]          r_shift, n_shift;
    logic [3:0]          r_step, n_step;
    logic [7:0]          r_low_hold, n_low_hold;
    logic                r_presence, n_presence;
    logic [2:0]          r_active, n_active;
    logic [15:0]         r_temp, n_temp;
    logic [7:0]          r_last_read, n_last_read;
    logic                r_out_valid;
    owtm_pkg::t_out_item r_out;

    logic in_take;
    logic n_pull;
    logic n_done;
    logic el;
    logic op_done;
    logic cur_bit;
    logic [owtm_pkg::CfgWidth-1:0] dur;

    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;

    function automatic logic [15:0] scale_temp(input logic [15:0] raw);
        logic [15:0] mag;
        logic [18:0] prod;
        logic [15:0] t;
        mag  = raw[15] ? (16'd0 - raw) : raw;
        prod = {1'b0, mag, 2'b00} + {3'b000, mag};
        t    = prod[18:3];
        return raw[15] ? (16'd0 - t) : t;
    endfunction

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bit_idx   = r_bit_idx;
        n_shift     = r_shift;
        n_step      = r_step;
        n_low_hold  = r_low_hold;
        n_presence  = r_presence;
        n_active    = r_active;
        n_temp      = r_temp;
        n_last_read = r_last_read;
        n_pull      = 1'b0;
        n_done      = 1'b0;
        el          = 1'b0;
        op_done     = 1'b0;
        dur         = '0;

        if (r_phase == PH_IDLE && (i_in_data.req_type == owtm_pkg::REQ_RESET
                || i_in_data.req_type == owtm_pkg::REQ_WRITE
                || i_in_data.req_type == owtm_pkg::REQ_READ
                || i_in_data.req_type == owtm_pkg::REQ_TEMP)) begin
            n_active = i_in_data.req_type;
            n_step   = owtm_pkg::STEP_RESET_A;
            n_tick   = '0;
            unique case (i_in_data.req_type)
                owtm_pkg::REQ_WRITE: begin
                    n_shift   = i_in_data.wr_byte;
                    n_bit_idx = 3'd0;
                    n_phase   = PH_WR_LOW;
                end
                owtm_pkg::REQ_READ: begin
                    n_shift   = 8'd0;
                    n_bit_idx = 3'd0;
                    n_phase   = PH_RD_LOW;
                end
                default: n_phase = PH_RST_LOW;
            endcase
        end

        cur_bit = n_shift[0];
        unique case (n_phase)
            PH_RST_LOW:   dur = r_cfg[owtm_pkg::CFG_RST_LOW];
            PH_RST_REL:   dur = r_cfg[owtm_pkg::CFG_RST_REL];
            PH_PRES_WAIT: dur = r_cfg[owtm_pkg::CFG_PRES_WAIT];
            PH_PRES_END:  dur = r_cfg[owtm_pkg::CFG_PRES_END];
            PH_WR_LOW:    dur = cur_bit ? r_cfg[owtm_pkg::CFG_SHORT]
                                        : r_cfg[owtm_pkg::CFG_LONG];
            PH_WR_REC:    dur = cur_bit ? r_cfg[owtm_pkg::CFG_LONG]
                                        : r_cfg[owtm_pkg::CFG_SHORT];
            PH_RD_LOW:    dur = r_cfg[owtm_pkg::CFG_SHORT];
            PH_RD_WAIT:   dur = r_cfg[owtm_pkg::CFG_RD_SAMPLE];
            PH_RD_TAIL:   dur = r_cfg[owtm_pkg::CFG_RD_TAIL];
            default:      dur = '0;
        endcase

        // a presence edge short-circuits the counter, so it only advances otherwise
        if (n_phase != PH_IDLE
                && !((n_phase == PH_PRES_WAIT || n_phase == PH_PRES_END)
                     && (i_in_data.line_in == (n_phase == PH_PRES_END)))) begin
            n_tick = n_tick + 1'b1;
            if (n_tick >= CW'(dur)) begin
                n_tick = '0;
                el     = 1'b1;
            end
        end

        unique case (n_phase)
            PH_IDLE: ;
            PH_RST_LOW: begin
                n_pull = 1'b1;
                if (el) n_phase = PH_RST_REL;
            end
            PH_RST_REL: begin
                if (el) n_phase = PH_PRES_WAIT;
            end
            PH_PRES_WAIT: begin
                if (!i_in_data.line_in) begin
                    n_tick  = '0;
                    n_phase = PH_PRES_END;
                end else if (el) begin
                    n_presence = 1'b1;
                    op_done    = 1'b1;
                end
            end
            PH_PRES_END: begin
                if (i_in_data.line_in) begin
                    n_presence = 1'b0;
                    n_tick     = '0;
                    op_done    = 1'b1;
                end else if (el) begin
                    n_presence = 1'b1;
                    op_done    = 1'b1;
                end
            end
            PH_WR_LOW: begin
                n_pull = 1'b1;
                if (el) n_phase = PH_WR_REC;
            end
            PH_WR_REC: begin
                if (el) begin
                    n_shift = {1'b0, n_shift[7:1]};
                    if (n_bit_idx == 3'd7) begin
                        op_done = 1'b1;
                    end else begin
                        n_bit_idx = n_bit_idx + 3'd1;
                        n_phase   = PH_WR_LOW;
                    end
                end
            end
            PH_RD_LOW: begin
                n_pull = 1'b1;
                if (el) n_phase = PH_RD_WAIT;
            end
            PH_RD_WAIT: begin
                if (el) begin
                    n_shift = {i_in_data.line_in, n_shift[7:1]};
                    n_phase = PH_RD_TAIL;
                end
            end
            PH_RD_TAIL: begin
                if (el) begin
                    if (n_bit_idx == 3'd7) begin
                        n_last_read = n_shift;
                        op_done     = 1'b1;
                    end else begin
                        n_bit_idx = n_bit_idx + 3'd1;
                        n_phase   = PH_RD_LOW;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase

        if (op_done) begin
            if (n_active == owtm_pkg::REQ_TEMP && n_step < owtm_pkg::STEP_RD_HI) begin
                if (n_step == owtm_pkg::STEP_RD_LO) n_low_hold = n_last_read;
                n_step = n_step + 4'd1;
                n_tick = '0;
                unique case (n_step)
                    owtm_pkg::STEP_RESET_B: n_phase = PH_RST_LOW;
                    owtm_pkg::STEP_SKIP_A, owtm_pkg::STEP_SKIP_B,
                    owtm_pkg::STEP_CONVERT, owtm_pkg::STEP_RD_PAD: begin
                        n_shift   = (n_step == owtm_pkg::STEP_CONVERT)
                                    ? owtm_pkg::CMD_CONVERT
                                    : (n_step == owtm_pkg::STEP_RD_PAD)
                                    ? owtm_pkg::CMD_READ_PAD
                                    : owtm_pkg::CMD_SKIP_ROM;
                        n_bit_idx = 3'd0;
                        n_phase   = PH_WR_LOW;
                    end
                    default: begin
                        n_shift   = 8'd0;
                        n_bit_idx = 3'd0;
                        n_phase   = PH_RD_LOW;
                    end
                endcase
            end else begin
                if (n_active == owtm_pkg::REQ_TEMP) begin
                    n_temp = scale_temp({n_last_read, n_low_hold});
                end
                n_phase = PH_IDLE;
                n_tick  = '0;
                n_done  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[owtm_pkg::CFG_RST_LOW]   <= owtm_pkg::DEF_RST_LOW;
            r_cfg[owtm_pkg::CFG_RST_REL]   <= owtm_pkg::DEF_RST_REL;
            r_cfg[owtm_pkg::CFG_PRES_WAIT] <= owtm_pkg::DEF_PRES_WAIT;
            r_cfg[owtm_pkg::CFG_PRES_END]  <= owtm_pkg::DEF_PRES_END;
            r_cfg[owtm_pkg::CFG_SHORT]     <= owtm_pkg::DEF_SHORT;
            r_cfg[owtm_pkg::CFG_LONG]      <= owtm_pkg::DEF_LONG;
            r_cfg[owtm_pkg::CFG_RD_SAMPLE] <= owtm_pkg::DEF_RD_SAMPLE;
            r_cfg[owtm_pkg::CFG_RD_TAIL]   <= owtm_pkg::DEF_RD_TAIL;
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit_idx   <= '0;
            r_shift     <= '0;
            r_step      <= '0;
            r_low_hold  <= '0;
            r_presence  <= 1'b0;
            r_active    <= '0;
            r_temp      <= '0;
            r_last_read <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            if (in_take) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit_idx   <= n_bit_idx;
                r_shift     <= n_shift;
                r_step      <= n_step;
                r_low_hold  <= n_low_hold;
                r_presence  <= n_presence;
                r_active    <= n_active;
                r_temp      <= n_temp;
                r_last_read <= n_last_read;
                r_out_valid <= 1'b1;
                r_out.line_pull_low <= n_pull;
                r_out.busy_res      <= (n_phase != PH_IDLE);
                r_out.done_res      <= n_done;
                r_out.presence_fail <= n_presence;
                r_out.rd_byte       <= n_last_read;
                r_out.temperature   <= n_temp;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res)
        else $error("done reported while still busy");

    a_pull_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.line_pull_low |-> o_out_data.busy_res)
        else $error("bus driven low outside a command");

    a_idle_count_clear: assert property (@(posedge i_clk)
        r_phase == PH_IDLE |-> r_tick == '0)
        else $error("tick counter left running in idle");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_phase) && $stable(r_tick))
        else $error("state advanced without an input transfer");
`endif

endmodule
